// ----- rtl/ipa_pkg.sv -----
// Types, codes and constants shared by the injector pulse accumulator.
package ipa_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_PULSE = 2'd0;
    localparam logic [1:0] CMD_VOLT  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL  = 3'd4;

    localparam logic [10:0] BASE_RESET      = 11'd750;
    localparam logic [9:0]  SLOPE_RESET     = 10'd120;
    localparam logic [15:0] MAX_RESET       = 16'd50000;
    localparam logic [10:0] FLOOR_RESET     = 11'd400;
    localparam logic [10:0] CEIL_RESET      = 11'd1500;
    localparam logic [10:0] DEAD_TIME_RESET = 11'd774;

    localparam logic [14:0] V_MIN_MV = 15'd10000;
    localparam logic [14:0] V_MAX_MV = 15'd15000;
    localparam logic [14:0] V_REF_MV = 15'd14000;

    // floor(x / 1000) == (x * RECIP_1000) >> 31, exact for x below 2^21
    localparam logic [21:0] RECIP_1000 = 22'd2147484;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        pulse_level;
        logic [15:0] pulse_width_us;
        logic [14:0] bus_millivolts;
    } t_in_item;

    typedef struct packed {
        logic [31:0] period_open_us;
        logic [15:0] period_pulses;
        logic [31:0] missed_total;
        logic [10:0] dead_time_now;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_write;

endpackage

// ----- rtl/ipa_chan_if.sv -----
// Valid/ready channel interface carrying one payload.
interface ipa_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/injector_pulse_accumulator.sv -----
// Injector pulse accumulator: dead time latch, period open-time totals, missed count.
//
//  channel | dir | payload                                              | transfer
//  i_in    | in  | cmd, pulse_level, pulse_width_us, bus_millivolts     | valid & ready
//  o_out   | out | period_open_us, period_pulses, missed_total,         | valid & ready
//          |     | dead_time_now (one per period tick)                  |
//  i_cfg   | in  | index, value (register write)                        | valid & ready
//
// One item per cycle unless a tick stalls stage 2; stage 2 registers each tick's result.
// Stage 1 forms the voltage product, stage 2 divides by 1000, clamps and updates the totals.
// A tick stalls stage 2 only while the output register holds an untaken result.
// Reset is synchronous; registers and totals return to their defaults.
module injector_pulse_accumulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipa_chan_if.sink   i_in,
    ipa_chan_if.source o_out,
    ipa_chan_if.sink   i_cfg
);

    logic [10:0] r_base;
    logic [9:0]  r_slope;
    logic [15:0] r_max;
    logic [10:0] r_floor;
    logic [10:0] r_ceil;

    logic [10:0] r_dead_time;
    logic [31:0] r_open_sum;
    logic [15:0] r_pulse_cnt;
    logic [31:0] r_missed;

    logic            r_s1_valid;
    ipa_pkg::t_in_item r_s1_item;
    logic            r_s2_valid;
    ipa_pkg::t_in_item r_s2_item;
    logic signed [26:0] r_s2_x;

    logic              r_out_valid;
    ipa_pkg::t_out_item r_out_data;

    logic s2_go;
    logic s2_free;
    logic s1_free;

    // stage 1: x = base*1000 + (14000 - v)*slope
    logic [14:0]        v_clamp;
    logic signed [15:0] v_diff;
    logic signed [26:0] v_prod;
    logic [20:0]        base_k;
    logic signed [26:0] n_x;

    // stage 2
    logic [20:0] lo_k;
    logic [20:0] hi_k;
    logic [42:0] q_prod;
    logic [10:0] q_dt;
    logic [10:0] n_dead_time;
    logic        pulse_open;
    logic        pulse_good;
    logic        pulse_miss;
    logic [15:0] corr;
    logic [32:0] sum_ext;
    logic [31:0] n_open_sum;
    logic [15:0] n_pulse_cnt;
    logic [31:0] n_missed;

    assign s2_go   = r_s2_valid && ((r_s2_item.cmd != ipa_pkg::CMD_TICK) ||
                                    !r_out_valid || o_out.ready);
    assign s2_free = !r_s2_valid || s2_go;
    assign s1_free = !r_s1_valid || s2_free;

    assign i_in.ready  = s1_free;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        if (r_s1_item.bus_millivolts < ipa_pkg::V_MIN_MV) begin
            v_clamp = ipa_pkg::V_MIN_MV;
        end else if (r_s1_item.bus_millivolts > ipa_pkg::V_MAX_MV) begin
            v_clamp = ipa_pkg::V_MAX_MV;
        end else begin
            v_clamp = r_s1_item.bus_millivolts;
        end
    end

    assign v_diff = $signed({1'b0, ipa_pkg::V_REF_MV}) - $signed({1'b0, v_clamp});
    assign v_prod = 27'(v_diff * $signed({1'b0, r_slope}));
    assign base_k = {10'b0, r_base} * 21'd1000;
    assign n_x    = $signed({6'b0, base_k}) + v_prod;

    assign lo_k   = {10'b0, r_floor} * 21'd1000;
    assign hi_k   = {10'b0, r_ceil} * 21'd1000;
    assign q_prod = {22'b0, r_s2_x[20:0]} * {21'b0, ipa_pkg::RECIP_1000};
    assign q_dt   = q_prod[41:31];

    always_comb begin
        if (r_s2_x < $signed({6'b0, lo_k})) begin
            n_dead_time = r_floor;
        end else if (r_s2_x > $signed({6'b0, hi_k})) begin
            n_dead_time = r_ceil;
        end else begin
            n_dead_time = q_dt;
        end
    end

    assign pulse_open = (r_s2_item.cmd == ipa_pkg::CMD_PULSE) && !r_s2_item.pulse_level &&
                        (r_s2_item.pulse_width_us != 16'd0);
    assign pulse_good = pulse_open && (r_s2_item.pulse_width_us > {5'b0, r_dead_time}) &&
                        (r_s2_item.pulse_width_us < r_max);
    assign pulse_miss = pulse_open && (r_s2_item.pulse_width_us >= r_max);

    assign corr    = r_s2_item.pulse_width_us - {5'b0, r_dead_time};
    assign sum_ext = {1'b0, r_open_sum} + {17'b0, corr};

    assign n_open_sum  = sum_ext[32] ? '1 : sum_ext[31:0];
    assign n_pulse_cnt = (r_pulse_cnt == '1) ? r_pulse_cnt : r_pulse_cnt + 16'd1;
    assign n_missed    = (r_missed == '1) ? r_missed : r_missed + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= ipa_pkg::BASE_RESET;
            r_slope <= ipa_pkg::SLOPE_RESET;
            r_max   <= ipa_pkg::MAX_RESET;
            r_floor <= ipa_pkg::FLOOR_RESET;
            r_ceil  <= ipa_pkg::CEIL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                ipa_pkg::REG_BASE:  r_base  <= i_cfg.data.value[10:0];
                ipa_pkg::REG_SLOPE: r_slope <= i_cfg.data.value[9:0];
                ipa_pkg::REG_MAX:   r_max   <= i_cfg.data.value;
                ipa_pkg::REG_FLOOR: r_floor <= i_cfg.data.value[10:0];
                ipa_pkg::REG_CEIL:  r_ceil  <= i_cfg.data.value[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_item <= i_in.data;
        end
        if (s2_free) begin
            r_s2_item <= r_s1_item;
            r_s2_x    <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time <= ipa_pkg::DEAD_TIME_RESET;
            r_open_sum  <= '0;
            r_pulse_cnt <= '0;
            r_missed    <= '0;
        end else if (s2_go) begin
            priority if (r_s2_item.cmd == ipa_pkg::CMD_VOLT) begin
                r_dead_time <= n_dead_time;
            end else if (r_s2_item.cmd == ipa_pkg::CMD_TICK) begin
                r_open_sum  <= '0;
                r_pulse_cnt <= '0;
            end else if (pulse_good) begin
                r_open_sum  <= n_open_sum;
                r_pulse_cnt <= n_pulse_cnt;
            end else if (pulse_miss) begin
                r_missed <= n_missed;
            end else begin
                r_missed <= r_missed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && (r_s2_item.cmd == ipa_pkg::CMD_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && (r_s2_item.cmd == ipa_pkg::CMD_TICK)) begin
            r_out_data.period_open_us <= r_open_sum;
            r_out_data.period_pulses  <= r_pulse_cnt;
            r_out_data.missed_total   <= r_missed;
            r_out_data.dead_time_now  <= r_dead_time;
        end
    end

    a_tick_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && (r_s2_item.cmd == ipa_pkg::CMD_TICK) |=> r_out_valid)
        else $error("tick left stage 2 without a result");

    a_tick_clears_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && (r_s2_item.cmd == ipa_pkg::CMD_TICK) |=>
        (r_open_sum == 32'd0) && (r_pulse_cnt == 16'd0))
        else $error("period totals not cleared after tick");

    a_missed_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_missed >= $past(r_missed)))
        else $error("missed count decreased");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule

// ----- bench/injector_pulse_accumulator_tb.sv -----
// Self-checking bench for the injector pulse accumulator: directed table, then random phases.
`timescale 1ns / 1ps

module injector_pulse_accumulator_tb;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         NUM_PHASES    = 9;
    localparam int         ZERO_DT_PHASE = 7;
    localparam int         PHASE_ITEMS   = 175;
    localparam int         DRAIN_WAIT    = 8;
    localparam int         HOLD_AFTER    = 300;
    localparam int         HOLD_CYCLES   = 400;
    localparam longint     CYCLE_LIMIT   = 200000;

    typedef struct {
        ipa_pkg::t_in_item  stim;
        bit                 typed;
        ipa_pkg::t_out_item want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipa_chan_if #(.t_payload(ipa_pkg::t_in_item))   in_ch ();
    ipa_chan_if #(.t_payload(ipa_pkg::t_out_item))  out_ch ();
    ipa_chan_if #(.t_payload(ipa_pkg::t_cfg_write)) cfg_ch ();

    injector_pulse_accumulator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block: registers and period state
    logic [10:0] base_us;
    logic [9:0]  slope_us;
    logic [15:0] max_us;
    logic [10:0] floor_us;
    logic [10:0] ceil_us;
    logic [10:0] dt_now;
    logic [31:0] open_sum;
    logic [15:0] pulse_cnt;
    logic [31:0] missed_cnt;

    ipa_pkg::t_out_item expected_totals [$];
    t_directed_row      directed_rows [$];
    int unsigned        error_count = 0;
    int unsigned        items_taken = 0;
    longint             cycle_count = 0;
    bit                 quiet = 1'b0;
    int unsigned        gap_rate = 0;

    function automatic logic [10:0] dead_time_for(input logic [14:0] mv);
        int v;
        int x;
        v = int'(mv);
        if (v < int'(ipa_pkg::V_MIN_MV)) v = int'(ipa_pkg::V_MIN_MV);
        if (v > int'(ipa_pkg::V_MAX_MV)) v = int'(ipa_pkg::V_MAX_MV);
        x = int'(base_us) * 1000 + (int'(ipa_pkg::V_REF_MV) - v) * int'(slope_us);
        if (x < int'(floor_us) * 1000) return floor_us;
        if (x > int'(ceil_us) * 1000) return ceil_us;
        return 11'(x / 1000);
    endfunction

    task automatic advance_totals(input ipa_pkg::t_in_item it, output bit has,
                                  output ipa_pkg::t_out_item totals);
        logic [31:0] corr;
        has = 1'b0;
        totals = '0;
        case (it.cmd)
            ipa_pkg::CMD_PULSE: begin
                if (!it.pulse_level && it.pulse_width_us != 16'd0) begin
                    if (it.pulse_width_us > dt_now && it.pulse_width_us < max_us) begin
                        corr = 32'(it.pulse_width_us) - 32'(dt_now);
                        if (open_sum > 32'hFFFF_FFFF - corr) open_sum = 32'hFFFF_FFFF;
                        else open_sum = open_sum + corr;
                        if (pulse_cnt != 16'hFFFF) pulse_cnt = pulse_cnt + 16'd1;
                    end else if (it.pulse_width_us >= max_us) begin
                        if (missed_cnt != 32'hFFFF_FFFF) missed_cnt = missed_cnt + 32'd1;
                    end
                end
            end
            ipa_pkg::CMD_VOLT: dt_now = dead_time_for(it.bus_millivolts);
            ipa_pkg::CMD_TICK: begin
                has = 1'b1;
                totals.period_open_us = open_sum;
                totals.period_pulses  = pulse_cnt;
                totals.missed_total   = missed_cnt;
                totals.dead_time_now  = dt_now;
                open_sum  = '0;
                pulse_cnt = '0;
            end
            default: ;
        endcase
    endtask

    function automatic t_directed_row drow(input logic [1:0] c, input logic lvl,
                                           input logic [15:0] w, input logic [14:0] mv,
                                           input bit typed = 1'b0,
                                           input logic [31:0] open = '0,
                                           input logic [15:0] cnt = '0,
                                           input logic [31:0] miss = '0,
                                           input logic [10:0] dt = '0);
        t_directed_row r;
        r.stim.cmd            = c;
        r.stim.pulse_level    = lvl;
        r.stim.pulse_width_us = w;
        r.stim.bus_millivolts = mv;
        r.typed               = typed;
        r.want.period_open_us = open;
        r.want.period_pulses  = cnt;
        r.want.missed_total   = miss;
        r.want.dead_time_now  = dt;
        return r;
    endfunction

    function automatic ipa_pkg::t_in_item make_item();
        ipa_pkg::t_in_item it;
        int unsigned       pick;
        it.pulse_level    = ($urandom_range(0, 7) == 0);
        it.bus_millivolts = ($urandom_range(0, 1) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(9000, 16000));
        case ($urandom_range(0, 5))
            0: it.pulse_width_us = 16'($urandom);
            1: it.pulse_width_us = 16'(int'(dt_now) + int'($urandom_range(0, 4)) - 2);
            2: it.pulse_width_us = 16'(int'(max_us) + int'($urandom_range(0, 4)) - 2);
            3: it.pulse_width_us = 16'($urandom_range(0, 8));
            default: it.pulse_width_us = 16'($urandom_range(int'(dt_now), int'(max_us)));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70)      it.cmd = ipa_pkg::CMD_PULSE;
        else if (pick < 82) it.cmd = ipa_pkg::CMD_VOLT;
        else if (pick < 94) it.cmd = ipa_pkg::CMD_TICK;
        else                it.cmd = CMD_UNUSED;
        return it;
    endfunction

    task automatic offer_item(input ipa_pkg::t_in_item it, input bit typed,
                              input ipa_pkg::t_out_item want);
        bit                 has;
        ipa_pkg::t_out_item totals;
        if (!quiet && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        items_taken++;
        advance_totals(it, has, totals);
        if (has) expected_totals.push_back(typed ? want : totals);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] vals [8]);
        ipa_pkg::t_cfg_write wr;
        for (int k = 0; k < 8; k++) begin
            wr.index = k[ipa_pkg::CFG_IDX_W-1:0];
            wr.value = vals[k];
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= wr;
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (wr.index)
                ipa_pkg::REG_BASE:  base_us  = wr.value[10:0];
                ipa_pkg::REG_SLOPE: slope_us = wr.value[9:0];
                ipa_pkg::REG_MAX:   max_us   = wr.value;
                ipa_pkg::REG_FLOOR: floor_us = wr.value[10:0];
                ipa_pkg::REG_CEIL:  ceil_us  = wr.value[10:0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge i_clk) begin : check_totals
        ipa_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_totals.size() == 0) begin
                report("result transfer with none pending", 32'd0, 32'd1);
            end else begin
                want = expected_totals.pop_front();
                if (out_ch.data.period_open_us != want.period_open_us)
                    report("period_open_us", want.period_open_us, out_ch.data.period_open_us);
                if (out_ch.data.period_pulses != want.period_pulses)
                    report("period_pulses", 32'(want.period_pulses),
                           32'(out_ch.data.period_pulses));
                if (out_ch.data.missed_total != want.missed_total)
                    report("missed_total", want.missed_total, out_ch.data.missed_total);
                if (out_ch.data.dead_time_now != want.dead_time_now)
                    report("dead_time_now", 32'(want.dead_time_now),
                           32'(out_ch.data.dead_time_now));
            end
        end
    end

    // result side: short random stalls, one long hold-off to back up the pipe
    int unsigned rx_idle_left = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_seg_left  = 0;
    bit          rx_hold_done = 1'b0;
    bit          rx_idle_en   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!rx_hold_done && items_taken >= HOLD_AFTER) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_seg_left == 0) begin
                rx_seg_left = $urandom_range(32, 256);
                rx_idle_en  = ($urandom_range(0, 2) != 0);
            end else begin
                rx_seg_left--;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_left != 0) begin
                rx_idle_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en && !quiet && $urandom_range(0, 5) == 0) begin
                rx_idle_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("injector_pulse_accumulator_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0]       cfg_vals [8];
        ipa_pkg::t_in_item it;
        t_directed_row     r;
        int unsigned       useful;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        base_us    = ipa_pkg::BASE_RESET;
        slope_us   = ipa_pkg::SLOPE_RESET;
        max_us     = ipa_pkg::MAX_RESET;
        floor_us   = ipa_pkg::FLOOR_RESET;
        ceil_us    = ipa_pkg::CEIL_RESET;
        dt_now     = ipa_pkg::DEAD_TIME_RESET;
        open_sum   = '0;
        pulse_cnt  = '0;
        missed_cnt = '0;

        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd0, 16'd0, 32'd0, 11'd774));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd0, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b1, 16'd65535, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd774, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd775, 15'd32767));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd49999, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd50000, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd65535, 15'd0));
        directed_rows.push_back(drow(CMD_UNUSED, 1'b0, 16'd1000, 15'd32767));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b1, 16'd65535, 15'd32767, 1'b1,
                                     32'd49226, 16'd2, 32'd2, 11'd774));
        directed_rows.push_back(drow(ipa_pkg::CMD_VOLT, 1'b0, 16'd0, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd0, 16'd0, 32'd2, 11'd1230));
        directed_rows.push_back(drow(ipa_pkg::CMD_VOLT, 1'b1, 16'd65535, 15'd32767));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd1000, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd370, 16'd1, 32'd2, 11'd630));
        directed_rows.push_back(drow(ipa_pkg::CMD_VOLT, 1'b0, 16'd0, 15'd14000));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd0, 16'd0, 32'd2, 11'd750));
        directed_rows.push_back(drow(ipa_pkg::CMD_VOLT, 1'b0, 16'd0, 15'd13800));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b0, 16'd1, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_PULSE, 1'b1, 16'd2000, 15'd0));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd0, 16'd0, 32'd2, 11'd774));
        directed_rows.push_back(drow(ipa_pkg::CMD_VOLT, 1'b0, 16'd0, 15'd10500));
        directed_rows.push_back(drow(ipa_pkg::CMD_TICK, 1'b0, 16'd0, 15'd0, 1'b1,
                                     32'd0, 16'd0, 32'd2, 11'd1170));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_rate = 3;
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            offer_item(r.stim, r.typed, r.want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            for (int k = 0; k < 8; k++) cfg_vals[k] = 16'($urandom);
            case (ph)
                0: begin
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'(ipa_pkg::BASE_RESET);
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'(ipa_pkg::SLOPE_RESET);
                    cfg_vals[ipa_pkg::REG_MAX]   = ipa_pkg::MAX_RESET;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'(ipa_pkg::FLOOR_RESET);
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'(ipa_pkg::CEIL_RESET);
                end
                1: begin
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'd0;
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'd0;
                    cfg_vals[ipa_pkg::REG_MAX]   = 16'd1;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'd0;
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'd0;
                end
                2: begin
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'd2047;
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'd1023;
                    cfg_vals[ipa_pkg::REG_MAX]   = 16'd65535;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'd0;
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'd2047;
                end
                3: begin
                    // floor above ceiling, max of zero
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'd0;
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'd1023;
                    cfg_vals[ipa_pkg::REG_MAX]   = 16'd0;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'd2047;
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'd0;
                end
                4: begin
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'd1000;
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'd500;
                    cfg_vals[ipa_pkg::REG_MAX]   = 16'd30000;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'd600;
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'd1800;
                end
                ZERO_DT_PHASE: begin
                    // dead time zero, widest max
                    cfg_vals[ipa_pkg::REG_BASE]  = 16'd0;
                    cfg_vals[ipa_pkg::REG_SLOPE] = 16'd0;
                    cfg_vals[ipa_pkg::REG_MAX]   = 16'd65535;
                    cfg_vals[ipa_pkg::REG_FLOOR] = 16'd0;
                    cfg_vals[ipa_pkg::REG_CEIL]  = 16'd0;
                end
                default: ;
            endcase
            program_regs(cfg_vals);

            quiet    = (ph == NUM_PHASES - 1);
            gap_rate = (ph == ZERO_DT_PHASE) ? 0 : $urandom_range(0, 4);

            // tick still reports the old dead time, then latch the new one
            it = make_item();
            it.cmd = ipa_pkg::CMD_TICK;
            offer_item(it, 1'b0, '0);
            it = make_item();
            it.cmd = ipa_pkg::CMD_VOLT;
            offer_item(it, 1'b0, '0);

            useful = 0;
            while (useful < PHASE_ITEMS) begin
                it = make_item();
                if (it.cmd != CMD_UNUSED &&
                    !(it.cmd == ipa_pkg::CMD_PULSE &&
                      (it.pulse_level || it.pulse_width_us == 16'd0)))
                    useful++;
                offer_item(it, 1'b0, '0);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("injector_pulse_accumulator_tb: clean");
        end else begin
            $display("injector_pulse_accumulator_tb: errors");
        end
        $finish;
    end

endmodule
